/* src/csd_pkg.sv */
// Shared types and constants for the complex spectrum divider.
package csd_pkg;

   localparam int DataWidth = 32;
   localparam int FracBits  = 16;
   localparam int MagWidth  = 64;
   localparam int RemWidth  = MagWidth + FracBits;
   localparam int CmpWidth  = MagWidth + DataWidth;
   localparam int QuoBits   = DataWidth;
   localparam int IdxWidth  = $clog2(QuoBits);

   localparam logic [DataWidth-1:0] PosLimit = {1'b0, {(DataWidth-1){1'b1}}};
   localparam logic [DataWidth-1:0] NegLimit = {1'b1, {(DataWidth-1){1'b0}}};

   typedef struct packed {
      logic [RemWidth-1:0]  rem;
      logic [MagWidth-1:0]  dvs;
      logic [QuoBits-1:0]   quo;
      logic                 neg;
      logic                 ovf;
   } lane_type;

   typedef struct packed {
      logic     vld;
      lane_type re;
      lane_type im;
      logic     real_only;
      logic     zero_den;
      logic     mag_zero;
   } div_type;

endpackage

/* src/complex_spectrum_divider.sv */
// Top level of the complex spectrum divider.
// Takes one element pair per cycle and returns one quotient per beat. The
// pipeline has four front stages (products, sums, magnitudes, overflow
// check), 32 restoring division stages that each settle one quotient bit for both
// the real and imaginary lanes, and the output register. The whole pipeline
// advances while the output register is empty or being taken, so a stall at the
// result side holds every stage and the input. The conjugate mode bit is sampled
// with each beat as it enters.
module complex_spectrum_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic                               csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [csd_pkg::DataWidth-1:0] req_a_real,
   input  logic signed [csd_pkg::DataWidth-1:0] req_a_imag,
   input  logic signed [csd_pkg::DataWidth-1:0] req_b_real,
   input  logic signed [csd_pkg::DataWidth-1:0] req_b_imag,
   input  logic                               req_real_only,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [csd_pkg::DataWidth-1:0] rsp_c_real,
   output logic signed [csd_pkg::DataWidth-1:0] rsp_c_imag,
   output logic                               rsp_saturated
);

   logic             conj_ff, en;
   csd_pkg::div_type chain [0:csd_pkg::QuoBits];

   always_ff @(posedge clock) begin
      if (reset) begin
         conj_ff <= 1'b0;
      end else if (csr_wr_en) begin
         conj_ff <= csr_wr_data;
      end
   end

   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   csd_front u_front (
      .clock, .reset, .en,
      .in_vld(req_valid),
      .a_real(req_a_real), .a_imag(req_a_imag),
      .b_real(req_b_real), .b_imag(req_b_imag),
      .real_only(req_real_only),
      .conj(conj_ff),
      .out(chain[0])
   );

   for (genvar k = 0; k < csd_pkg::QuoBits; k++) begin : g_div
      csd_div_stage u_stage (
         .clock, .reset, .en,
         .bit_idx(csd_pkg::IdxWidth'(csd_pkg::QuoBits - 1 - k)),
         .in(chain[k]),
         .out(chain[k+1])
      );
   end

   csd_back u_back (
      .clock, .reset, .en,
      .in(chain[csd_pkg::QuoBits]),
      .rsp_valid,
      .c_real(rsp_c_real),
      .c_imag(rsp_c_imag),
      .saturated(rsp_saturated)
   );

endmodule

/* src/csd_front.sv */
// Front end: products, sums, magnitudes, divisor and overflow check.
module csd_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_vld,
   input  logic signed [csd_pkg::DataWidth-1:0] a_real,
   input  logic signed [csd_pkg::DataWidth-1:0] a_imag,
   input  logic signed [csd_pkg::DataWidth-1:0] b_real,
   input  logic signed [csd_pkg::DataWidth-1:0] b_imag,
   input  logic                               real_only,
   input  logic                               conj,
   output csd_pkg::div_type                   out
);

   logic                vld1_ff, ro1_ff, cj1_ff;
   logic signed [31:0]  ar1_ff, br1_ff;
   logic signed [63:0]  prr_ff, pii_ff, pir_ff, pri_ff, sqr_ff, sqi_ff;

   logic                vld2_ff, ro2_ff;
   logic signed [65:0]  nre2_ff, nim2_ff, nre2_in, nim2_in;
   logic [63:0]         den2_ff, den2_in;
   logic signed [31:0]  ar2_ff;
   logic signed [32:0]  brp2_ff;

   logic                vld3_ff, ro3_ff, nre3_ff, nim3_ff;
   logic [63:0]         mre3_ff, mim3_ff, d3_ff, mre3_in, mim3_in, d3_in;
   logic                nre3_in, nim3_in;
   logic [65:0]         absre, absim;
   logic [32:0]         absar, absden;

   csd_pkg::div_type    out_ff, out_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         out_ff.vld <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ro1_ff <= real_only;
         cj1_ff <= conj;
         ar1_ff <= a_real;
         br1_ff <= b_real;
         prr_ff <= a_real * b_real;
         pii_ff <= a_imag * b_imag;
         pir_ff <= a_imag * b_real;
         pri_ff <= a_real * b_imag;
         sqr_ff <= b_real * b_real;
         sqi_ff <= b_imag * b_imag;

         ro2_ff  <= ro1_ff;
         nre2_ff <= nre2_in;
         nim2_ff <= nim2_in;
         den2_ff <= den2_in;
         ar2_ff  <= ar1_ff;
         brp2_ff <= 33'(br1_ff) + 33'sd1;

         ro3_ff  <= ro2_ff;
         nre3_ff <= nre3_in;
         nim3_ff <= nim3_in;
         mre3_ff <= mre3_in;
         mim3_ff <= mim3_in;
         d3_ff   <= d3_in;
      end
   end

   always_comb begin
      if (cj1_ff) begin
         nre2_in = 66'(prr_ff) - 66'(pii_ff);
         nim2_in = 66'(pir_ff) + 66'(pri_ff);
      end else begin
         nre2_in = 66'(prr_ff) + 66'(pii_ff);
         nim2_in = 66'(pir_ff) - 66'(pri_ff);
      end
      den2_in = 64'(sqr_ff) + 64'(sqi_ff) + 64'd1;
   end

   always_comb begin
      absre  = nre2_ff[65] ? 66'(-nre2_ff) : 66'(nre2_ff);
      absim  = nim2_ff[65] ? 66'(-nim2_ff) : 66'(nim2_ff);
      absar  = ar2_ff[31] ? 33'(-33'(ar2_ff)) : 33'(ar2_ff);
      absden = brp2_ff[32] ? 33'(-brp2_ff) : 33'(brp2_ff);
      if (ro2_ff) begin
         mre3_in = 64'(absar);
         nre3_in = ar2_ff[31] ^ brp2_ff[32];
         d3_in   = 64'(absden);
      end else begin
         mre3_in = absre[63:0];
         nre3_in = nre2_ff[65];
         d3_in   = den2_ff;
      end
      mim3_in = absim[63:0];
      nim3_in = nim2_ff[65];
   end

   always_comb begin
      out_in.vld       = vld3_ff;
      out_in.real_only = ro3_ff;
      out_in.zero_den  = (d3_ff == '0);
      out_in.mag_zero  = (mre3_ff == '0);
      out_in.re.rem    = {mre3_ff, {csd_pkg::FracBits{1'b0}}};
      out_in.re.dvs    = d3_ff;
      out_in.re.quo    = '0;
      out_in.re.neg    = nre3_ff;
      out_in.re.ovf    = {{csd_pkg::FracBits{1'b0}}, mre3_ff} >= {d3_ff, {csd_pkg::FracBits{1'b0}}};
      out_in.im.rem    = {mim3_ff, {csd_pkg::FracBits{1'b0}}};
      out_in.im.dvs    = d3_ff;
      out_in.im.quo    = '0;
      out_in.im.neg    = nim3_ff;
      out_in.im.ovf    = {{csd_pkg::FracBits{1'b0}}, mim3_ff} >= {d3_ff, {csd_pkg::FracBits{1'b0}}};
   end

   assign out = out_ff;

endmodule

/* src/csd_div_stage.sv */
// One restoring division step that settles one quotient bit per lane.
module csd_div_stage (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic [csd_pkg::IdxWidth-1:0]      bit_idx,
   input  csd_pkg::div_type                  in,
   output csd_pkg::div_type                  out
);

   csd_pkg::div_type stage_ff, stage_in;

   function automatic csd_pkg::lane_type step(csd_pkg::lane_type l,
                                              logic [csd_pkg::IdxWidth-1:0] idx);
      logic [csd_pkg::CmpWidth-1:0] rem_w;
      logic [csd_pkg::CmpWidth-1:0] sub_w;
      csd_pkg::lane_type            r;
      rem_w = csd_pkg::CmpWidth'(l.rem);
      sub_w = csd_pkg::CmpWidth'(l.dvs) << idx;
      r = l;
      if (rem_w >= sub_w) begin
         r.rem      = csd_pkg::RemWidth'(rem_w - sub_w);
         r.quo[idx] = 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      stage_in    = in;
      stage_in.re = step(in.re, bit_idx);
      stage_in.im = step(in.im, bit_idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.vld <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign out = stage_ff;

endmodule

/* src/csd_back.sv */
// Back end: sign, saturation and the result register.
module csd_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  csd_pkg::div_type                   in,
   output logic                               rsp_valid,
   output logic signed [csd_pkg::DataWidth-1:0] c_real,
   output logic signed [csd_pkg::DataWidth-1:0] c_imag,
   output logic                               saturated
);

   logic                          vld_ff;
   logic [csd_pkg::DataWidth-1:0] cre_ff, cim_ff, cre_in, cim_in;
   logic                          sat_ff, sat_in, sre, sim;

   function automatic logic [csd_pkg::DataWidth:0] finish(csd_pkg::lane_type l);
      logic                          s;
      logic [csd_pkg::DataWidth-1:0] v;
      if (l.neg) begin
         s = l.ovf || (l.quo[csd_pkg::QuoBits-1] && (l.quo[csd_pkg::QuoBits-2:0] != '0));
         v = s ? csd_pkg::NegLimit : csd_pkg::DataWidth'(-l.quo);
      end else begin
         s = l.ovf || l.quo[csd_pkg::QuoBits-1];
         v = s ? csd_pkg::PosLimit : l.quo;
      end
      return {s, v};
   endfunction

   always_comb begin
      {sre, cre_in} = finish(in.re);
      {sim, cim_in} = finish(in.im);
      if (in.real_only) begin
         cim_in = '0;
         if (in.zero_den) begin
            sat_in = 1'b1;
            cre_in = in.mag_zero ? '0 : (in.re.neg ? csd_pkg::NegLimit : csd_pkg::PosLimit);
         end else begin
            sat_in = sre;
         end
      end else begin
         sat_in = sre | sim;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cre_ff <= cre_in;
         cim_ff <= cim_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_valid = vld_ff;
   assign c_real    = cre_ff;
   assign c_imag    = cim_ff;
   assign saturated = sat_ff;

endmodule

/* src/csd_checker.sv */
// Port-level checks for the complex spectrum divider, bound to the top level.
module csd_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [csd_pkg::DataWidth-1:0] rsp_c_real,
   input logic signed [csd_pkg::DataWidth-1:0] rsp_c_imag,
   input logic                               rsp_saturated
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_c_real)
         && $stable(rsp_c_imag) && $stable(rsp_saturated))
      else $error("Stalled result beat changed.");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("Input taken while result is stalled.");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("Input stalled while output is empty.");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Result valid right after reset.");

endmodule

bind complex_spectrum_divider csd_checker u_csd_checker (.*);
